// ----- hw/rtl/assert_macros.svh -----
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is held
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// next-cycle implication, off while reset is held
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ----- hw/rtl/mbe_pkg.sv -----
package mbe_pkg;

	// width of the c input ports
	localparam int C_W = 32;

	// max_iterations after reset, cut to the count width at the top level
	localparam int RESET_MAX_ITER = 256;

	typedef struct packed {
		logic load;    // take a new point, clear z and count
		logic step;    // one z = z*z + c step
		logic finish;  // capture the result word
	} cmd_t;

	typedef struct packed {
		logic at_max;   // count has reached max_iterations
		logic escaped;  // current z has |z|^2 >= 4
	} status_t;

endpackage

// ----- hw/rtl/mbe_ctrl.sv -----
module mbe_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  mbe_pkg::status_t   status,
	output mbe_pkg::cmd_t      cmd,
	output logic               busy,
	output logic               done
);

	typedef enum logic {
		S_IDLE,
		S_RUN
	} state_t;

	state_t state_q;
	logic   done_q;
	logic   stop;

	assign stop = status.at_max || status.escaped;

	always_comb begin
		cmd.load   = (state_q == S_IDLE) && start;
		cmd.step   = (state_q == S_RUN) && !stop;
		cmd.finish = (state_q == S_RUN) && stop;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (stop) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

// ----- hw/rtl/mbe_datapath.sv -----
module mbe_datapath #(
	parameter int FRACTION_BITS = 28,
	parameter int COUNT_BITS    = 12
) (
	input  logic                              clk,
	input  mbe_pkg::cmd_t                     cmd,
	input  logic signed [mbe_pkg::C_W-1:0]    c_real,
	input  logic signed [mbe_pkg::C_W-1:0]    c_imag,
	input  logic        [COUNT_BITS-1:0]      max_iterations,
	output mbe_pkg::status_t                  status,
	output logic        [COUNT_BITS-1:0]      iteration_count,
	output logic                              inside_set
);

	// z in [-2, 2) fits SW bits; each square is then at most 2^(2F+2)
	localparam int SW = FRACTION_BITS + 2;
	localparam int PW = 2 * SW;
	localparam int DW = 2 * FRACTION_BITS + 3;
	localparam int ZW = ((FRACTION_BITS + 4 > mbe_pkg::C_W) ?
		FRACTION_BITS + 4 : mbe_pkg::C_W) + 1;

	logic signed [ZW-1:0]           zr_q, zi_q;
	logic signed [mbe_pkg::C_W-1:0] cr_q, ci_q;
	logic        [COUNT_BITS-1:0]   count_q;
	logic        [COUNT_BITS-1:0]   result_count_q;
	logic                           result_inside_q;

	logic              fits_r, fits_i;
	logic signed [SW-1:0] zr_n, zi_n;
	logic signed [PW-1:0] rr, ii, ri;
	logic signed [PW:0]   twice;
	logic        [DW:0]   mag;
	logic signed [DW-1:0] diff;
	logic signed [ZW-1:0] zr_next, zi_next;

	// a part outside [-2, 2) is an escape without looking at the squares
	assign fits_r = (zr_q[ZW-1:SW-1] == {(ZW-SW+1){zr_q[SW-1]}});
	assign fits_i = (zi_q[ZW-1:SW-1] == {(ZW-SW+1){zi_q[SW-1]}});
	assign zr_n   = zr_q[SW-1:0];
	assign zi_n   = zi_q[SW-1:0];

	assign rr = zr_n * zr_n;
	assign ii = zi_n * zi_n;
	assign ri = zr_n * zi_n;

	// the escape test of one step is done at the start of the next
	assign mag   = {1'b0, rr[DW-1:0]} + {1'b0, ii[DW-1:0]};
	assign diff  = $signed(rr[DW-1:0]) - $signed(ii[DW-1:0]);
	assign twice = {ri, 1'b0};

	assign zr_next = ZW'(diff >>> FRACTION_BITS) + ZW'(cr_q);
	assign zi_next = ZW'(twice >>> FRACTION_BITS) + ZW'(ci_q);

	assign status.escaped = !fits_r || !fits_i || (mag[DW:DW-1] != 2'b00);
	assign status.at_max  = (count_q == max_iterations);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			zr_q    <= '0;
			zi_q    <= '0;
			cr_q    <= c_real;
			ci_q    <= c_imag;
			count_q <= '0;
		end else if (cmd.step) begin
			zr_q    <= zr_next;
			zi_q    <= zi_next;
			count_q <= count_q + 1'b1;
		end
		if (cmd.finish) begin
			result_count_q  <= count_q;
			result_inside_q <= status.at_max;
		end
	end

	assign iteration_count = result_count_q;
	assign inside_set      = result_inside_q;

endmodule

// ----- hw/rtl/mandelbrot_escape_time.sv -----
// Mandelbrot escape-time engine. A point c (signed fixed point, FRACTION_BITS
// fraction bits) is taken when start is high and busy is low. The engine runs
// one z = z*z + c step per clock through three multipliers in the datapath,
// stopping at max_iterations or once |z|^2 reaches 4. A point occupies the
// engine from accept to done, and max_iterations is 256 after reset. The
// result word (iteration_count, inside_set) is marked by done for exactly
// one cycle and cannot be held off; the ports keep it until the next result.
// busy falls in the done cycle, so the next point may be started then.
// max_iterations is written through cfg_valid/cfg_data; the user must write
// it only while the engine is idle, as the block itself does not enforce this.
// A value of zero gives count 0 with inside_set high.
`include "assert_macros.svh"

module mandelbrot_escape_time #(
	parameter int FRACTION_BITS = 28,
	parameter int COUNT_BITS    = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic signed [mbe_pkg::C_W-1:0]  c_real,
	input  logic signed [mbe_pkg::C_W-1:0]  c_imag,
	output logic                            done,
	output logic        [COUNT_BITS-1:0]    iteration_count,
	output logic                            inside_set,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic        [COUNT_BITS-1:0]    cfg_data
);

	mbe_pkg::cmd_t    cmd;
	mbe_pkg::status_t status;

	logic [COUNT_BITS-1:0] max_iterations_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iterations_q <= COUNT_BITS'(mbe_pkg::RESET_MAX_ITER);
		end else if (cfg_valid && cfg_ready) begin
			max_iterations_q <= cfg_data;
		end
	end

	mbe_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	mbe_datapath #(
		.FRACTION_BITS (FRACTION_BITS),
		.COUNT_BITS    (COUNT_BITS)
	) u_datapath (
		.clk             (clk),
		.cmd             (cmd),
		.c_real          (c_real),
		.c_imag          (c_imag),
		.max_iterations  (max_iterations_q),
		.status          (status),
		.iteration_count (iteration_count),
		.inside_set      (inside_set)
	);

	`ASSERT_IMPLIES(a_done_idle, clk, arst_n, done, !busy)
	`ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`ASSERT_IMPLIES(a_inside_count, clk, arst_n, done && inside_set, iteration_count == max_iterations_q)
	`ASSERT_IMPLIES(a_finish_once, clk, arst_n, cmd.finish, !cmd.step && !cmd.load)

endmodule

// ----- tb/sv/tb_mandelbrot_escape_time.sv -----
`timescale 1ns / 100ps

module tb_mandelbrot_escape_time;

	localparam int C_W     = mbe_pkg::C_W;
	localparam int FRAC    = 28;
	localparam int COUNT_W = 12;
	localparam int ONE     = 1 << FRAC;
	localparam logic signed [127:0] FOUR_SQ = 128'sd1 << (2 * FRAC + 2);

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               in_set;
	} escape_result_t;

	typedef struct packed {
		logic [COUNT_W-1:0]    max_it;
		logic signed [C_W-1:0] cr;
		logic signed [C_W-1:0] ci;
		logic                  typed;
		logic [COUNT_W-1:0]    count;
		logic                  in_set;
	} point_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic signed [C_W-1:0] c_real = '0;
	logic signed [C_W-1:0] c_imag = '0;
	logic cfg_valid = 1'b0;
	logic [COUNT_W-1:0] cfg_data = '0;
	logic busy, done, inside_set, cfg_ready;
	logic [COUNT_W-1:0] iteration_count;

	escape_result_t pending_q[$];
	logic [COUNT_W-1:0] max_now = 12'd256;
	int errors = 0;

	localparam int N_ROWS = 25;
	// typed rows: points whose escape count is obvious; the rest go through the predictor
	point_row_t rows [0:N_ROWS-1] = '{
		'{12'd256,  32'h0000_0000, 32'h0000_0000, 1'b1, 12'd256,  1'b1},
		'{12'd256,  32'hE000_0000, 32'h0000_0000, 1'b1, 12'd1,    1'b0},
		'{12'd256,  32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 12'd1,    1'b0},
		'{12'd256,  32'h8000_0000, 32'h8000_0000, 1'b1, 12'd1,    1'b0},
		'{12'd256,  32'h8000_0000, 32'h0000_0000, 1'b1, 12'd1,    1'b0},
		'{12'd256,  32'h0000_0000, 32'h7FFF_FFFF, 1'b1, 12'd1,    1'b0},
		'{12'd256,  32'hF000_0000, 32'h0000_0000, 1'b1, 12'd256,  1'b1},
		'{12'd256,  32'h0000_0000, 32'h1000_0000, 1'b1, 12'd256,  1'b1},
		'{12'd256,  32'h2000_0000, 32'h0000_0000, 1'b1, 12'd1,    1'b0},
		'{12'd256,  32'h0000_0000, 32'hE000_0000, 1'b1, 12'd1,    1'b0},
		'{12'd256,  32'hE000_0000, 32'hE000_0000, 1'b1, 12'd1,    1'b0},
		'{12'd256,  32'h0400_0000, 32'h0000_0000, 1'b0, 12'd0,    1'b0},
		'{12'd256,  32'h0400_0001, 32'h0000_0000, 1'b0, 12'd0,    1'b0},
		'{12'd256,  32'h0800_0000, 32'h0000_0000, 1'b0, 12'd0,    1'b0},
		'{12'd256,  32'hE000_0001, 32'h0000_0000, 1'b0, 12'd0,    1'b0},
		'{12'd256,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 12'd0,    1'b0},
		'{12'd256,  32'h0000_0001, 32'h0000_0000, 1'b0, 12'd0,    1'b0},
		'{12'd256,  32'hF400_0000, 32'h0100_0000, 1'b0, 12'd0,    1'b0},
		'{12'd1,    32'h0000_0000, 32'h0000_0000, 1'b1, 12'd1,    1'b1},
		'{12'd1,    32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 12'd1,    1'b1},
		'{12'd0,    32'h1234_5678, 32'h9ABC_DEF0, 1'b1, 12'd0,    1'b1},
		'{12'd0,    32'h0000_0000, 32'h0000_0000, 1'b1, 12'd0,    1'b1},
		'{12'd4095, 32'h0000_0000, 32'h0000_0000, 1'b1, 12'd4095, 1'b1},
		'{12'd4095, 32'hF000_0000, 32'h0000_0000, 1'b1, 12'd4095, 1'b1},
		'{12'd4095, 32'hE000_0000, 32'h0000_0000, 1'b1, 12'd1,    1'b0}
	};

	mandelbrot_escape_time #(
		.FRACTION_BITS(FRAC),
		.COUNT_BITS(COUNT_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.c_real(c_real),
		.c_imag(c_imag),
		.done(done),
		.iteration_count(iteration_count),
		.inside_set(inside_set),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic escape_result_t predict_escape(input logic signed [C_W-1:0] cr,
			input logic signed [C_W-1:0] ci, input logic [COUNT_W-1:0] max_it);
		logic signed [63:0] zr, zi, cr64, ci64;
		logic signed [127:0] wr, wi, diff, twice, mag;
		int steps;
		bit escaped;
		escape_result_t res;
		cr64 = cr;
		ci64 = ci;
		zr = '0;
		zi = '0;
		steps = 0;
		escaped = 1'b0;
		while (steps < max_it && !escaped) begin
			wr = zr;
			wi = zi;
			diff = (wr * wr - wi * wi) >>> FRAC;
			twice = ((wr * wi) <<< 1) >>> FRAC;
			zr = diff[63:0] + cr64;
			zi = twice[63:0] + ci64;
			steps++;
			wr = zr;
			wi = zi;
			mag = wr * wr + wi * wi;
			escaped = (mag >= FOUR_SQ);
		end
		res.count = steps[COUNT_W-1:0];
		res.in_set = (steps == max_it);
		return res;
	endfunction

	// the engine cannot stall results, so every done edge takes one word
	always @(posedge clk) begin : result_check
		escape_result_t want;
		if (arst_n && done) begin
			if (pending_q.size() == 0) begin
				$error("unexpected word: iteration_count %0d inside_set %0d",
					iteration_count, inside_set);
				errors++;
			end else begin
				want = pending_q.pop_front();
				if (iteration_count !== want.count) begin
					$error("iteration_count expected %0d, got %0d", want.count, iteration_count);
					errors++;
				end
				if (inside_set !== want.in_set) begin
					$error("inside_set expected %0d, got %0d", want.in_set, inside_set);
					errors++;
				end
			end
		end
	end

	task automatic send_point(input logic signed [C_W-1:0] cr, input logic signed [C_W-1:0] ci,
			input bit typed, input escape_result_t typed_res);
		start <= 1'b1;
		c_real <= cr;
		c_imag <= ci;
		do @(posedge clk); while (busy);
		if (typed)
			pending_q.push_back(typed_res);
		else
			pending_q.push_back(predict_escape(cr, ci, max_now));
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (pending_q.size() != 0);
	endtask

	task automatic write_max(input logic [COUNT_W-1:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		max_now = value;
	endtask

	task automatic idle_gap();
		start <= 1'b0;
		// half the gaps start at the end of the current point, so they hit the done cycle
		if ($urandom_range(0, 1)) begin
			do @(posedge clk); while (busy);
			repeat ($urandom_range(0, 6)) @(posedge clk);
		end else begin
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic pick_point(output logic signed [C_W-1:0] cr, output logic signed [C_W-1:0] ci);
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 15) begin
			cr = $urandom;
			ci = $urandom;
		end else if (sel < 40) begin
			// cardioid and period-2 bulb, mostly long runs
			cr = int'($urandom_range(0, 3 * ONE / 2)) - 5 * ONE / 4;
			ci = int'($urandom_range(0, 3 * ONE / 2)) - 3 * ONE / 4;
		end else begin
			cr = int'($urandom_range(0, 3 * ONE)) - 9 * ONE / 4;
			ci = int'($urandom_range(0, 3 * ONE)) - 3 * ONE / 2;
		end
	endtask

	task automatic run_phase(input logic [COUNT_W-1:0] max_it, input int n_points,
			input int idle_pct, input bit hold_off);
		logic signed [C_W-1:0] cr, ci;
		write_max(max_it);
		for (int i = 0; i < n_points; i++) begin
			if (hold_off && i == n_points / 2)
				drain_results();
			if ($urandom_range(0, 99) < idle_pct)
				idle_gap();
			pick_point(cr, ci);
			send_point(cr, ci, 1'b0, '0);
		end
	endtask

	initial begin
		#20_000_000;
		$display("FAIL mandelbrot_escape_time");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_ROWS; r++) begin
			if (rows[r].max_it != max_now)
				write_max(rows[r].max_it);
			if ($urandom_range(0, 99) < 26)
				idle_gap();
			send_point(rows[r].cr, rows[r].ci, rows[r].typed, {rows[r].count, rows[r].in_set});
		end

		run_phase(12'($urandom_range(2, 31)), 150, 26, 1'b0);
		run_phase(12'($urandom_range(32, 300)), 150, 0, 1'b0);
		run_phase(12'd1, 60, 26, 1'b0);
		run_phase(12'($urandom_range(2, 300)), 150, 26, 1'b1);
		run_phase(12'd4095, 6, 26, 1'b0);
		run_phase(12'($urandom_range(2, 4095)), 8, 26, 1'b0);
		run_phase(12'($urandom_range(16, 256)), 200, 26, 1'b0);

		drain_results();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("PASS mandelbrot_escape_time");
		else
			$display("FAIL mandelbrot_escape_time");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/mbe_pkg.sv
hw/rtl/mbe_ctrl.sv
hw/rtl/mbe_datapath.sv
hw/rtl/mandelbrot_escape_time.sv
tb/sv/tb_mandelbrot_escape_time.sv
